FILE: hdl/nbsg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nbsg_pkg: shared types and constants of the softened gravity block
// Register indexes, status codes, fixed-point limits and the sequencer states.
// ----------------------------------------------------------------------------
package nbsg_pkg;

    localparam int MAX_BODIES_DEF = 64;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRAV_CONST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFTENING_SQ = 2'd1;

    localparam logic [31:0] GRAV_RESET = 32'h0100_0000;
    localparam logic [31:0] SOFT_RESET = 32'h0000_0000;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FEW     = 2'd1;
    localparam logic [1:0] STATUS_DROPPED = 2'd2;

    localparam logic [47:0] MAG_CAP = 48'h8000_0000_0000;
    localparam logic [47:0] ACC_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] ACC_MIN = 48'h8000_0000_0000;

    typedef struct packed {
        logic [31:0] mass;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_body;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RDI,
        S_RDJ,
        S_DIFF,
        S_SQ_GO,
        S_SQ_WAIT,
        S_SOFT,
        S_RT_GO,
        S_RT_WAIT,
        S_DEN_GO,
        S_DEN_WAIT,
        S_GM_GO,
        S_GM_WAIT,
        S_NUM_GO,
        S_NUM_WAIT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_ACC_RD,
        S_ACC_WR,
        S_NEXT,
        S_OUT_RD,
        S_OUT_EMIT
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/nbsg_wmul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nbsg_wmul: 64 by 64 bit multiplier over one 32 by 32 bit multiplier
// Four partial products are formed one per cycle and summed into 128 bits.
// ----------------------------------------------------------------------------
module nbsg_wmul
    import nbsg_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [63:0]  i_a,
    input  wire logic [63:0]  i_b,
    output logic              o_done,
    output logic [127:0]      o_prod
);

    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [127:0] r_acc;
    logic [63:0]  r_pp;
    logic [1:0]   r_sh;
    logic         r_ppv;
    logic [2:0]   r_cnt;
    logic         r_run;
    logic         r_done;

    logic [31:0]  op_a;
    logic [31:0]  op_b;
    logic [1:0]   op_sh;
    logic [127:0] addend;

    always_comb begin
        case (r_cnt[1:0])
            2'd0: begin op_a = r_a[31:0];  op_b = r_b[31:0];  op_sh = 2'd0; end
            2'd1: begin op_a = r_a[31:0];  op_b = r_b[63:32]; op_sh = 2'd1; end
            2'd2: begin op_a = r_a[63:32]; op_b = r_b[31:0];  op_sh = 2'd1; end
            default: begin op_a = r_a[63:32]; op_b = r_b[63:32]; op_sh = 2'd2; end
        endcase
        case (r_sh)
            2'd0: addend = {64'b0, r_pp};
            2'd1: addend = {32'b0, r_pp, 32'b0};
            2'd2: addend = {r_pp, 64'b0};
            default: addend = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_ppv  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_ppv  <= 1'b0;
                r_run  <= 1'b1;
                r_done <= 1'b0;
            end else if (r_run) begin
                if (r_cnt < 3'd4) begin
                    r_pp  <= {32'b0, op_a} * {32'b0, op_b};
                    r_sh  <= op_sh;
                    r_ppv <= 1'b1;
                end else begin
                    r_ppv <= 1'b0;
                end
                if (r_ppv) begin
                    r_acc <= r_acc + addend;
                end
                r_cnt  <= r_cnt + 3'd1;
                r_done <= (r_cnt == 3'd4);
                if (r_cnt == 3'd4) begin
                    r_run <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

FILE: hdl/nbsg_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nbsg_sqrt: digit-by-digit square root of r2 * 2^32
// One result bit per cycle into a 48-bit root, floor of the exact root.
// ----------------------------------------------------------------------------
module nbsg_sqrt
    import nbsg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_r2,
    output logic             o_done,
    output logic [47:0]      o_root
);

    logic [95:0] r_x;
    logic [50:0] r_rem;
    logic [47:0] r_root;
    logic [5:0]  r_cnt;
    logic        r_run;
    logic        r_done;

    logic [50:0] rem_sh;
    logic [50:0] trial;
    logic        ge;

    assign rem_sh = {r_rem[48:0], r_x[95:94]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_x    <= {i_r2, 32'b0};
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_run  <= 1'b1;
                r_done <= 1'b0;
            end else if (r_run) begin
                r_x    <= {r_x[93:0], 2'b00};
                r_rem  <= ge ? (rem_sh - trial) : rem_sh;
                r_root <= {r_root[46:0], ge};
                r_cnt  <= r_cnt + 6'd1;
                r_done <= (r_cnt == 6'd47);
                if (r_cnt == 6'd47) begin
                    r_run <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

FILE: hdl/nbsg_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nbsg_div: restoring divider for one force component
// Quotient of a 128-bit numerator by a 112-bit denominator, capped at 2^47.
// ----------------------------------------------------------------------------
module nbsg_div
    import nbsg_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [127:0] i_num,
    input  wire logic [111:0] i_den,
    output logic              o_done,
    output logic [47:0]       o_mag
);

    logic [112:0] r_rem;
    logic [111:0] r_den;
    logic [47:0]  r_low;
    logic [47:0]  r_q;
    logic [5:0]   r_cnt;
    logic         r_cap;
    logic         r_run;
    logic         r_done;

    logic [112:0] rem_sh;
    logic         ge;
    logic         big;

    assign rem_sh = {r_rem[111:0], r_low[47]};
    assign ge     = (rem_sh >= {1'b0, r_den});
    assign big    = ({32'b0, i_num[127:48]} >= i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_cap  <= 1'b0;
        end else begin
            if (i_start) begin
                r_den <= i_den;
                r_rem <= {33'b0, i_num[127:48]};
                r_low <= i_num[47:0];
                r_q   <= '0;
                r_cnt <= '0;
                r_cap <= big;
                r_run <= !big;
                r_done <= big;
            end else if (r_run) begin
                r_rem  <= ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
                r_low  <= {r_low[46:0], 1'b0};
                r_q    <= {r_q[46:0], ge};
                r_cnt  <= r_cnt + 6'd1;
                r_done <= (r_cnt == 6'd47);
                if (r_cnt == 6'd47) begin
                    r_run <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_mag  = (r_cap || (r_q > MAG_CAP)) ? MAG_CAP : r_q;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_run)
        else $error("divider started while running");

endmodule

`default_nettype wire

FILE: hdl/nbody_softened_gravity_accel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nbody_softened_gravity_accel: direct N-body gravity with Plummer softening
//
// Channel   Direction  Handshake                   Payload
// input     in         start & !busy               i_body_mass, i_pos_x/y/z,
//                                                  i_final_body
// result    out        o_strobe, one cycle         o_body_index, o_acc_x/y/z,
//                                                  o_status, o_last_result
// config    in         i_cfg_valid & o_cfg_ready   i_cfg_index, i_cfg_data
//
// A body item is taken on start while idle. The final item starts the pair
// pass over each pair i<j if two or more bodies are held, else gives one
// STATUS_FEW result. The pass spends most of its time in the 48-step divider
// that serves the six force components of each pair and in the 48-step root.
// Capped components skip the divider; coincident unsoftened pairs are skipped.
// Bodies and accelerations live in synchronous memories; each pair updates
// its two acceleration rows by read, add and write back.
// Reset is synchronous and active low. Results cannot be stalled.
// ----------------------------------------------------------------------------
module nbody_softened_gravity_accel
    import nbsg_pkg::*;
#(
    parameter int MAX_BODIES = MAX_BODIES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [31:0]          i_body_mass,
    input  wire logic signed [31:0]   i_pos_x,
    input  wire logic signed [31:0]   i_pos_y,
    input  wire logic signed [31:0]   i_pos_z,
    input  wire logic                 i_final_body,
    output logic                      o_strobe,
    output logic [5:0]                o_body_index,
    output logic signed [47:0]        o_acc_x,
    output logic signed [47:0]        o_acc_y,
    output logic signed [47:0]        o_acc_z,
    output logic [1:0]                o_status,
    output logic                      o_last_result,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_BODIES);
    localparam int CNT_W = $clog2(MAX_BODIES + 1);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic [CNT_W-1:0] r_i, n_i, r_j, n_j, r_e, n_e;
    logic [1:0]       r_k, n_k;
    logic             r_side, n_side;

    logic [31:0] r_grav;
    logic [31:0] r_soft;

    t_body       body_mem [MAX_BODIES];
    t_body       r_body_rd;
    t_body       r_bi;
    t_body       r_bj;
    logic [IDX_W-1:0] body_ra;

    logic [143:0] accel_mem [MAX_BODIES];
    logic [143:0] r_acc_rd;
    logic         r_rd_vld;
    logic [MAX_BODIES-1:0] r_acc_vld;
    logic [IDX_W-1:0] acc_ra;
    logic [IDX_W-1:0] acc_wa;
    logic [143:0] acc_wdata;

    logic [31:0]        r_dmag [3];
    logic               r_dneg [3];
    logic [63:0]        r_r2;
    logic [47:0]        r_q;
    logic [111:0]       r_den;
    logic [63:0]        r_gm;
    logic [95:0]        r_num;
    logic signed [48:0] r_contrib [3];

    logic        r_strobe;
    logic [5:0]  r_o_index;
    logic [47:0] r_o_x, r_o_y, r_o_z;
    logic [1:0]  r_o_status;
    logic        r_o_last;

    logic        accept;
    logic        body_we;
    logic        vld_clr;
    logic        emit_err;
    logic        emit_res;
    logic        emit_last;

    logic        mul_start;
    logic [63:0] mul_a, mul_b;
    logic        mul_done;
    logic [127:0] mul_prod;
    logic        rt_done;
    logic [47:0] rt_root;
    logic        div_done;
    logic [47:0] div_mag;

    logic [32:0] dx, dy, dz;
    logic [64:0] sq_sum;
    logic [64:0] soft_sum;
    logic [63:0] r2_sq;
    logic [63:0] r2_soft;

    function automatic logic [47:0] f_acc_add(input logic [47:0] old,
                                              input logic signed [48:0] c);
        logic signed [49:0] s;
        s = 50'($signed(old)) + 50'(c);
        if (s > 50'($signed(ACC_MAX))) begin
            return ACC_MAX;
        end else if (s < 50'($signed(ACC_MIN))) begin
            return ACC_MIN;
        end
        return s[47:0];
    endfunction

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign body_we     = accept && (r_count < CNT_W'(MAX_BODIES));
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= GRAV_RESET;
            r_soft <= SOFT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GRAV_CONST:   r_grav <= i_cfg_data;
                CFG_SOFTENING_SQ: r_soft <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign body_ra = (r_state == S_RDJ) ? r_j[IDX_W-1:0] : r_i[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (body_we) begin
            body_mem[r_count[IDX_W-1:0]] <= '{mass: i_body_mass, x: i_pos_x,
                                              y: i_pos_y, z: i_pos_z};
        end
        r_body_rd <= body_mem[body_ra];
    end

    assign acc_wa = r_side ? r_j[IDX_W-1:0] : r_i[IDX_W-1:0];
    assign acc_ra = (r_state == S_OUT_RD) ? r_e[IDX_W-1:0] : acc_wa;

    always_comb begin
        acc_wdata[47:0]   = f_acc_add(r_rd_vld ? r_acc_rd[47:0] : '0, r_contrib[0]);
        acc_wdata[95:48]  = f_acc_add(r_rd_vld ? r_acc_rd[95:48] : '0, r_contrib[1]);
        acc_wdata[143:96] = f_acc_add(r_rd_vld ? r_acc_rd[143:96] : '0, r_contrib[2]);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ACC_WR) begin
            accel_mem[acc_wa] <= acc_wdata;
        end
        r_acc_rd <= accel_mem[acc_ra];
        r_rd_vld <= r_acc_vld[acc_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld <= '0;
        end else if (vld_clr) begin
            r_acc_vld <= '0;
        end else if (r_state == S_ACC_WR) begin
            r_acc_vld[acc_wa] <= 1'b1;
        end
    end

    assign dx = 33'($signed(r_body_rd.x)) - 33'($signed(r_bi.x));
    assign dy = 33'($signed(r_body_rd.y)) - 33'($signed(r_bi.y));
    assign dz = 33'($signed(r_body_rd.z)) - 33'($signed(r_bi.z));

    assign sq_sum   = {1'b0, r_r2} + {1'b0, mul_prod[63:0]};
    assign r2_sq    = sq_sum[64] ? '1 : sq_sum[63:0];
    assign soft_sum = {1'b0, r_r2} + {17'b0, r_soft, 16'b0};
    assign r2_soft  = soft_sum[64] ? '1 : soft_sum[63:0];

    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (r_state)
            S_SQ_GO: begin
                mul_start = 1'b1;
                mul_a     = {32'b0, r_dmag[r_k]};
                mul_b     = {32'b0, r_dmag[r_k]};
            end
            S_DEN_GO: begin
                mul_start = 1'b1;
                mul_a     = r_r2;
                mul_b     = {16'b0, r_q};
            end
            S_GM_GO: begin
                mul_start = 1'b1;
                mul_a     = {32'b0, r_grav};
                mul_b     = {32'b0, r_side ? r_bi.mass : r_bj.mass};
            end
            S_NUM_GO: begin
                mul_start = 1'b1;
                mul_a     = r_gm;
                mul_b     = {32'b0, r_dmag[r_k]};
            end
            default: ;
        endcase
    end

    nbsg_wmul u_wmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    nbsg_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_RT_GO),
        .i_r2    (r_r2),
        .o_done  (rt_done),
        .o_root  (rt_root)
    );

    nbsg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIV_GO),
        .i_num   ({r_num, 32'b0}),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_mag   (div_mag)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_i       = r_i;
        n_j       = r_j;
        n_e       = r_e;
        n_k       = r_k;
        n_side    = r_side;
        vld_clr   = 1'b0;
        emit_err  = 1'b0;
        emit_res  = 1'b0;
        emit_last = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (body_we) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_final_body) begin
                        if (n_count < CNT_W'(2)) begin
                            emit_err = 1'b1;
                            n_count  = '0;
                            n_ovf    = 1'b0;
                        end else begin
                            vld_clr = 1'b1;
                            n_i     = '0;
                            n_j     = CNT_W'(1);
                            n_state = S_RDI;
                        end
                    end
                end
            end
            S_RDI:  n_state = S_RDJ;
            S_RDJ:  n_state = S_DIFF;
            S_DIFF: begin
                n_k     = '0;
                n_state = S_SQ_GO;
            end
            S_SQ_GO: n_state = S_SQ_WAIT;
            S_SQ_WAIT: begin
                if (mul_done) begin
                    if (r_k == 2'd2) begin
                        n_state = S_SOFT;
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_state = S_SQ_GO;
                    end
                end
            end
            S_SOFT: n_state = (r2_soft == '0) ? S_NEXT : S_RT_GO;
            S_RT_GO: n_state = S_RT_WAIT;
            S_RT_WAIT: begin
                if (rt_done) begin
                    n_state = S_DEN_GO;
                end
            end
            S_DEN_GO: n_state = S_DEN_WAIT;
            S_DEN_WAIT: begin
                if (mul_done) begin
                    n_side  = 1'b0;
                    n_state = S_GM_GO;
                end
            end
            S_GM_GO: n_state = S_GM_WAIT;
            S_GM_WAIT: begin
                if (mul_done) begin
                    n_k     = '0;
                    n_state = S_NUM_GO;
                end
            end
            S_NUM_GO: n_state = S_NUM_WAIT;
            S_NUM_WAIT: begin
                if (mul_done) begin
                    n_state = S_DIV_GO;
                end
            end
            S_DIV_GO: n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (div_done) begin
                    if (r_k == 2'd2) begin
                        n_state = S_ACC_RD;
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_state = S_NUM_GO;
                    end
                end
            end
            S_ACC_RD: n_state = S_ACC_WR;
            S_ACC_WR: begin
                if (!r_side) begin
                    n_side  = 1'b1;
                    n_state = S_GM_GO;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                n_state = S_RDI;
                if (r_j == r_count - CNT_W'(1)) begin
                    if (r_i == r_count - CNT_W'(2)) begin
                        n_e     = '0;
                        n_state = S_OUT_RD;
                    end else begin
                        n_i = r_i + CNT_W'(1);
                        n_j = r_i + CNT_W'(2);
                    end
                end else begin
                    n_j = r_j + CNT_W'(1);
                end
            end
            S_OUT_RD: n_state = S_OUT_EMIT;
            S_OUT_EMIT: begin
                emit_res = 1'b1;
                if (r_e == r_count - CNT_W'(1)) begin
                    emit_last = 1'b1;
                    n_count   = '0;
                    n_ovf     = 1'b0;
                    n_state   = S_IDLE;
                end else begin
                    n_e     = r_e + CNT_W'(1);
                    n_state = S_OUT_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_e      <= '0;
            r_k      <= '0;
            r_side   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_i      <= n_i;
            r_j      <= n_j;
            r_e      <= n_e;
            r_k      <= n_k;
            r_side   <= n_side;
            r_strobe <= emit_err || emit_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RDJ) begin
            r_bi <= r_body_rd;
        end
        if (r_state == S_DIFF) begin
            r_bj      <= r_body_rd;
            r_r2      <= '0;
            r_dneg[0] <= dx[32];
            r_dneg[1] <= dy[32];
            r_dneg[2] <= dz[32];
            r_dmag[0] <= dx[32] ? 32'(-dx) : dx[31:0];
            r_dmag[1] <= dy[32] ? 32'(-dy) : dy[31:0];
            r_dmag[2] <= dz[32] ? 32'(-dz) : dz[31:0];
        end
        if (r_state == S_SQ_WAIT && mul_done) begin
            r_r2 <= r2_sq;
        end
        if (r_state == S_SOFT) begin
            r_r2 <= r2_soft;
        end
        if (r_state == S_RT_WAIT && rt_done) begin
            r_q <= rt_root;
        end
        if (r_state == S_DEN_WAIT && mul_done) begin
            r_den <= mul_prod[111:0];
        end
        if (r_state == S_GM_WAIT && mul_done) begin
            r_gm <= mul_prod[63:0];
        end
        if (r_state == S_NUM_WAIT && mul_done) begin
            r_num <= mul_prod[95:0];
        end
        if (r_state == S_DIV_WAIT && div_done) begin
            r_contrib[r_k] <= (r_dneg[r_k] ^ r_side) ? -$signed({1'b0, div_mag})
                                                     : $signed({1'b0, div_mag});
        end
        if (emit_err) begin
            r_o_index  <= '0;
            r_o_x      <= '0;
            r_o_y      <= '0;
            r_o_z      <= '0;
            r_o_status <= STATUS_FEW;
            r_o_last   <= 1'b1;
        end else if (emit_res) begin
            r_o_index  <= 6'(r_e);
            r_o_x      <= r_rd_vld ? r_acc_rd[47:0] : '0;
            r_o_y      <= r_rd_vld ? r_acc_rd[95:48] : '0;
            r_o_z      <= r_rd_vld ? r_acc_rd[143:96] : '0;
            r_o_status <= r_ovf ? STATUS_DROPPED : STATUS_OK;
            r_o_last   <= emit_last;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_body_index  = r_o_index;
    assign o_acc_x       = r_o_x;
    assign o_acc_y       = r_o_y;
    assign o_acc_z       = r_o_z;
    assign o_status      = r_o_status;
    assign o_last_result = r_o_last;

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_o_last) |-> (r_count == '0))
        else $error("body count not cleared with the last result");

    a_busy_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("pair pass started without an accepted item");

    a_result_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_o_last) |=> !r_strobe)
        else $error("results of one batch issued back to back");

endmodule

`default_nettype wire

FILE: tb/sv/nbody_softened_gravity_accel_tb.sv
// ----------------------------------------------------------------------------
// nbody_softened_gravity_accel_tb: self-checking bench of the gravity block
// Loads batches of bodies under several gravity and softening settings,
// predicts the acceleration results in exact fixed point (typed rows give
// their own), and compares each result field by field as it leaves the block.
// ----------------------------------------------------------------------------
module nbody_softened_gravity_accel_tb
    import nbsg_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAXB        = MAX_BODIES_DEF;
    localparam longint      CYCLE_LIMIT = 6000000;
    localparam logic [31:0] ONE_Q16     = 32'h0001_0000;
    localparam longint      SACC_MAX    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint      SACC_MIN    = -64'sh0000_8000_0000_0000;

    typedef struct packed {
        logic [5:0]  index;
        logic [47:0] ax;
        logic [47:0] ay;
        logic [47:0] az;
        logic [1:0]  status;
        logic        last;
    } t_accel;

    typedef struct {
        logic [31:0] mass;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        bit          fin;
        bit          typed;
        int          nres;
        logic [1:0]  status;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_body_mass = '0;
    logic [31:0] i_pos_x = '0;
    logic [31:0] i_pos_y = '0;
    logic [31:0] i_pos_z = '0;
    logic        i_final_body = 1'b0;
    logic        o_strobe;
    logic [5:0]  o_body_index;
    logic [47:0] o_acc_x;
    logic [47:0] o_acc_y;
    logic [47:0] o_acc_z;
    logic [1:0]  o_status;
    logic        o_last_result;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    nbody_softened_gravity_accel u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_body_mass(i_body_mass), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y),
        .i_pos_z(i_pos_z), .i_final_body(i_final_body),
        .o_strobe(o_strobe), .o_body_index(o_body_index), .o_acc_x(o_acc_x),
        .o_acc_y(o_acc_y), .o_acc_z(o_acc_z), .o_status(o_status),
        .o_last_result(o_last_result), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor state.
    logic [31:0] grav_q;
    logic [31:0] soft_q;
    logic [31:0] mass_mem [MAXB];
    logic [31:0] px_mem [MAXB];
    logic [31:0] py_mem [MAXB];
    logic [31:0] pz_mem [MAXB];
    longint      accel_sum [3*MAXB];
    int          loaded;
    bit          dropped;

    t_accel accel_due[$];
    int     errors = 0;
    int     items_sent = 0;
    int     results_seen = 0;
    int     batches = 0;
    longint cycles = 0;
    bit     gaps_on;

    function automatic logic [63:0] scaled_root(logic [63:0] r);
        logic [127:0] x;
        logic [127:0] c;
        logic [63:0]  res;
        x = {32'b0, r, 32'b0};
        res = '0;
        for (int b = 47; b >= 0; b--) begin
            c = {64'b0, res | (64'd1 << b)};
            if (c * c <= x) res = c[63:0];
        end
        return res;
    endfunction

    function automatic longint pull_comp(logic [31:0] mass, longint d, logic [127:0] den);
        logic [63:0]  mag;
        logic [127:0] num;
        logic [127:0] q;
        longint       m;
        mag = d < 0 ? 64'(-d) : 64'(d);
        num = ((128'(grav_q) * 128'(mass)) * 128'(mag)) << 32;
        q = num / den;
        m = (q > 128'(MAG_CAP)) ? longint'(MAG_CAP) : longint'(q[63:0]);
        return d < 0 ? -m : m;
    endfunction

    function automatic longint sat_acc(longint a, longint v);
        longint s;
        s = a + v;
        if (s > SACC_MAX) return SACC_MAX;
        if (s < SACC_MIN) return SACC_MIN;
        return s;
    endfunction

    function automatic void pair_force(int i, int j);
        longint       d [3];
        logic [127:0] r2;
        logic [127:0] den;
        logic [63:0]  a;
        d[0] = longint'($signed(px_mem[j])) - longint'($signed(px_mem[i]));
        d[1] = longint'($signed(py_mem[j])) - longint'($signed(py_mem[i]));
        d[2] = longint'($signed(pz_mem[j])) - longint'($signed(pz_mem[i]));
        r2 = '0;
        for (int k = 0; k < 3; k++) begin
            a = d[k] < 0 ? 64'(-d[k]) : 64'(d[k]);
            r2 = r2 + 128'(a) * 128'(a);
            if (r2 > 128'(64'hFFFF_FFFF_FFFF_FFFF)) r2 = 128'(64'hFFFF_FFFF_FFFF_FFFF);
        end
        r2 = r2 + (128'(soft_q) << 16);
        if (r2 > 128'(64'hFFFF_FFFF_FFFF_FFFF)) r2 = 128'(64'hFFFF_FFFF_FFFF_FFFF);
        if (r2 == 0) return;
        den = r2 * 128'(scaled_root(r2[63:0]));
        for (int k = 0; k < 3; k++) begin
            accel_sum[3*i+k] = sat_acc(accel_sum[3*i+k], pull_comp(mass_mem[j], d[k], den));
            accel_sum[3*j+k] = sat_acc(accel_sum[3*j+k], -pull_comp(mass_mem[i], d[k], den));
        end
    endfunction

    function automatic void load_body(logic [31:0] m, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] z, bit fin, bit record);
        t_accel r;
        if (loaded < MAXB) begin
            mass_mem[loaded] = m;
            px_mem[loaded] = x;
            py_mem[loaded] = y;
            pz_mem[loaded] = z;
            loaded++;
        end else begin
            dropped = 1'b1;
        end
        if (!fin) return;
        if (loaded < 2) begin
            r = '{index: '0, ax: '0, ay: '0, az: '0, status: STATUS_FEW, last: 1'b1};
            if (record) accel_due.push_back(r);
        end else begin
            for (int k = 0; k < 3*MAXB; k++) accel_sum[k] = 0;
            for (int i = 0; i < loaded; i++)
                for (int j = i + 1; j < loaded; j++) pair_force(i, j);
            for (int i = 0; i < loaded; i++) begin
                r.index = 6'(i);
                r.ax = accel_sum[3*i][47:0];
                r.ay = accel_sum[3*i+1][47:0];
                r.az = accel_sum[3*i+2][47:0];
                r.status = dropped ? STATUS_DROPPED : STATUS_OK;
                r.last = (i + 1 == loaded);
                if (record) accel_due.push_back(r);
            end
        end
        loaded = 0;
        dropped = 1'b0;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (!gaps_on || p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_body(logic [31:0] m, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, bit fin, bit record);
        int g;
        i_body_mass <= m;
        i_pos_x <= x;
        i_pos_y <= y;
        i_pos_z <= z;
        i_final_body <= fin;
        start <= 1'b1;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        load_body(m, x, y, z, fin, record);
        items_sent++;
        g = pick_gap();
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (accel_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        if (idx == CFG_GRAV_CONST) grav_q = val;
        else if (idx == CFG_SOFTENING_SQ) soft_q = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_mass();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom_range(1, 32'h0010_0000);
        endcase
    endfunction

    task automatic random_batch(int n);
        gaps_on = $urandom_range(0, 3) != 0;
        for (int b = 0; b < n; b++)
            send_body(rand_mass(), rand_pos(), rand_pos(), rand_pos(), b == n - 1, 1'b1);
        batches++;
    endtask

    task automatic check_field(string name, logic [47:0] e, logic [47:0] a);
        if (e !== a) begin
            $error("%s expected %0h got %0h", name, e, a);
            errors++;
        end
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (accel_due.size() == 0) begin
                $error("result for body %0d with no item pending", o_body_index);
                errors++;
            end else begin
                t_accel e;
                e = accel_due.pop_front();
                check_field("body_index", 48'(e.index), 48'(o_body_index));
                check_field("acc_x", e.ax, o_acc_x);
                check_field("acc_y", e.ay, o_acc_y);
                check_field("acc_z", e.az, o_acc_z);
                check_field("status", 48'(e.status), 48'(o_status));
                check_field("last_result", 48'(e.last), 48'(o_last_result));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    t_row rows [] = '{
        '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1, 1, 1, STATUS_FEW},
        '{32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, STATUS_OK},
        '{32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1, 2, STATUS_OK},
        '{32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, STATUS_OK},
        '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 0, STATUS_OK},
        '{32'h0, 32'h0, 32'h0, 32'h0, 0, 0, 0, STATUS_OK},
        '{32'h0, ONE_Q16, 32'h0, 32'h0, 1, 1, 2, STATUS_OK},
        '{ONE_Q16, 32'h0, 32'h0, 32'h0, 0, 0, 0, STATUS_OK},
        '{ONE_Q16, ONE_Q16, 32'h0, 32'h0, 0, 0, 0, STATUS_OK},
        '{ONE_Q16, 32'h0, ONE_Q16, 32'h0, 0, 0, 0, STATUS_OK},
        '{32'h0002_0000, 32'h0, 32'h0, 32'hFFFF_0000, 1, 0, 0, STATUS_OK},
        '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 0, 0, 0, STATUS_OK},
        '{32'hFFFF_FFFF, 32'h1, 32'h0, 32'h0, 1, 0, 0, STATUS_OK},
        '{32'h5555_AAAA, 32'hAAAA_5555, 32'h5555_AAAA, 32'hFFFF_FFFF, 0, 0, 0, STATUS_OK},
        '{32'hAAAA_5555, 32'h5555_AAAA, 32'hAAAA_5555, 32'h0000_0001, 1, 0, 0, STATUS_OK},
        '{ONE_Q16, 32'h0, 32'h0, 32'h0, 1, 1, 1, STATUS_FEW}
    };

    logic [31:0] grav_set [5];
    logic [31:0] soft_set [5];

    initial begin
        t_accel r;
        grav_q = GRAV_RESET;
        soft_q = SOFT_RESET;
        loaded = 0;
        dropped = 1'b0;
        gaps_on = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            send_body(rows[k].mass, rows[k].x, rows[k].y, rows[k].z, rows[k].fin,
                      !rows[k].typed);
            if (rows[k].typed) begin
                for (int i = 0; i < rows[k].nres; i++) begin
                    r = '{index: 6'(i), ax: '0, ay: '0, az: '0, status: rows[k].status,
                          last: i == rows[k].nres - 1};
                    accel_due.push_back(r);
                end
            end
            if (rows[k].fin) batches++;
        end

        grav_set = '{32'hFFFF_FFFF, 32'h0, GRAV_RESET, $urandom, $urandom_range(1, 32'h00FF_FFFF)};
        soft_set = '{32'h0, 32'hFFFF_FFFF, ONE_Q16, $urandom, $urandom_range(0, 32'h000F_FFFF)};
        for (int p = 0; p < 5; p++) begin
            int sent0;
            wait_idle();
            if (p % 2 == 0) begin
                write_reg(CFG_GRAV_CONST, grav_set[p]);
                write_reg(CFG_SOFTENING_SQ, soft_set[p]);
            end else begin
                write_reg(CFG_SOFTENING_SQ, soft_set[p]);
                write_reg(CFG_GRAV_CONST, grav_set[p]);
            end
            @(posedge i_clk);
            // Capacity and overflow are run once, under unit gravity and softening.
            if (p == 2) random_batch(MAXB + 2);
            sent0 = items_sent;
            while (items_sent - sent0 < 45)
                random_batch($urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 6));
        end

        wait_idle();
        repeat (50) @(posedge i_clk);
        $display("Sent %0d bodies in %0d batches over 6 gravity/softening settings,",
                 items_sent, batches);
        $display("checked %0d acceleration results, %0d mismatches.", results_seen, errors);
        if (errors == 0 && accel_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
